>>> sv/rpbt_pkg.sv
// shared constants, types and register codes for the raster to page byte transpose unit
package rpbt_pkg;

    localparam int MAX_LINE_BYTES = 128;
    localparam int LS_AW          = $clog2(MAX_LINE_BYTES);
    localparam int ROWS_KEPT      = 7;
    localparam int LS_DW          = ROWS_KEPT * 8;
    localparam int MAX_WIDTH_PX   = MAX_LINE_BYTES * 8;
    localparam int WIDTH_W        = 11;
    localparam int POS_W          = 11;
    localparam int BPL_W          = $clog2(MAX_LINE_BYTES + 1);
    localparam int ROWLEN_W       = BPL_W + 1;

    localparam logic [2:0]         ROW_LAST      = 3'd7;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = WIDTH_W'(128);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX     = WIDTH_W'(MAX_WIDTH_PX);
    localparam logic [7:0]         INVERT_MASK   = 8'hff;

    typedef enum logic [1:0] {
        CFG_WIDTH_PIXELS  = 2'd0,
        CFG_PADDING_BYTES = 2'd1,
        CFG_INVERT        = 2'd2,
        CFG_BOTTOM_FIRST  = 2'd3
    } cfg_idx_t;

    // one eighth-row byte waiting for its line store read
    typedef struct packed {
        logic [7:0] last_row;
        logic [2:0] cnt_m1;
        logic       band_end;
    } blk_t;

endpackage

>>> sv/raster_to_page_byte_transpose_unit.sv
// top level: row and byte position tracking, line store access, column word output
//
//  port group   dir  handshake            payload
//  s_           in   s_valid / s_ready    s_data_byte, s_image_start
//  m_           out  m_valid / m_ready    m_column_byte, m_band_end, m_group_last
//  cfg_         in   cfg_wr_en            cfg_index, cfg_wdata
//
// pixel bytes of rows 0..6 are written to the line store at acceptance and padding bytes are
// dropped. an eighth-row pixel byte starts a registered line store read and then sends up to
// eight column words, one per cycle while m_ready is high, from the emitter's shift register.
// input stalls only while a read block waits for the emitter, so new bytes are taken while
// the emitter is still sending the column words of an earlier block.
// synchronous active-low reset clears positions, control and config; data and line store are kept.
module raster_to_page_byte_transpose_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [rpbt_pkg::WIDTH_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_image_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_column_byte,
    output logic                          m_band_end,
    output logic                          m_group_last
);

    logic [rpbt_pkg::WIDTH_W-1:0] width_reg;
    logic [1:0]                   padding_reg;
    logic                         invert_reg;
    logic                         bottom_first_reg;

    logic [2:0]                   row_reg, row_next;
    logic [rpbt_pkg::POS_W-1:0]   pos_reg, pos_next;

    logic                         st1_valid_reg, st1_valid_next;
    rpbt_pkg::blk_t               st1_blk_reg, st1_blk_next;

    logic [rpbt_pkg::WIDTH_W-1:0] eff_w;
    logic [rpbt_pkg::BPL_W-1:0]   bpl;
    logic [rpbt_pkg::ROWLEN_W-1:0] rowlen;
    logic [2:0]                   row_cur;
    logic [rpbt_pkg::POS_W-1:0]   pos_cur;
    logic [rpbt_pkg::POS_W:0]     pos_inc;
    logic                         pixel_byte;
    logic [rpbt_pkg::WIDTH_W-1:0] rem_px;
    logic                         accept;
    logic                         emit_item;
    logic                         blk_ready;
    logic                         wr_en;
    logic [rpbt_pkg::ROWS_KEPT-1:0] wr_lane;
    logic [rpbt_pkg::LS_DW-1:0]   held;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg        <= rpbt_pkg::WIDTH_RESET;
            padding_reg      <= 2'd0;
            invert_reg       <= 1'b0;
            bottom_first_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (rpbt_pkg::cfg_idx_t'(cfg_index))
                rpbt_pkg::CFG_WIDTH_PIXELS:  width_reg        <= cfg_wdata;
                rpbt_pkg::CFG_PADDING_BYTES: padding_reg      <= cfg_wdata[1:0];
                rpbt_pkg::CFG_INVERT:        invert_reg       <= cfg_wdata[0];
                rpbt_pkg::CFG_BOTTOM_FIRST:  bottom_first_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            eff_w = rpbt_pkg::WIDTH_W'(1);
        end else if (width_reg > rpbt_pkg::WIDTH_MAX) begin
            eff_w = rpbt_pkg::WIDTH_MAX;
        end else begin
            eff_w = width_reg;
        end
    end

    assign bpl    = rpbt_pkg::BPL_W'(({1'b0, eff_w} + 12'd7) >> 3);
    assign rowlen = rpbt_pkg::ROWLEN_W'(bpl) + rpbt_pkg::ROWLEN_W'(padding_reg);

    // image start restarts the position for this very byte
    assign row_cur = s_image_start ? 3'd0 : row_reg;
    assign pos_cur = s_image_start ? '0 : pos_reg;
    assign pos_inc = {1'b0, pos_cur} + 12'd1;

    assign pixel_byte = (pos_cur < rpbt_pkg::POS_W'(bpl));
    assign emit_item  = pixel_byte && (row_cur == rpbt_pkg::ROW_LAST);
    assign rem_px     = eff_w - {pos_cur[rpbt_pkg::POS_W-4:0], 3'b000};

    assign s_ready = !st1_valid_reg || blk_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        row_next = row_reg;
        pos_next = pos_reg;
        if (accept) begin
            if (pos_inc >= (rpbt_pkg::POS_W + 1)'(rowlen)) begin
                pos_next = '0;
                row_next = row_cur + 3'd1;
            end else begin
                pos_next = pos_inc[rpbt_pkg::POS_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_comb begin
        st1_valid_next = st1_valid_reg;
        st1_blk_next   = st1_blk_reg;
        if (st1_valid_reg && blk_ready) begin
            st1_valid_next = 1'b0;
        end
        if (accept && emit_item) begin
            st1_valid_next        = 1'b1;
            st1_blk_next.last_row = s_data_byte;
            st1_blk_next.cnt_m1   = (rem_px >= rpbt_pkg::WIDTH_W'(8)) ? 3'd7
                                                                    : rem_px[2:0] - 3'd1;
            st1_blk_next.band_end = (rem_px <= rpbt_pkg::WIDTH_W'(8));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= 3'd0;
            pos_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st1_blk_reg <= st1_blk_next;
    end

    assign wr_en   = accept && pixel_byte && (row_cur != rpbt_pkg::ROW_LAST);
    assign wr_lane = rpbt_pkg::ROWS_KEPT'(1) << row_cur;

    rpbt_line_store u_line_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pos_cur[rpbt_pkg::LS_AW-1:0]),
        .wr_lane (wr_lane),
        .wr_data (s_data_byte),
        .rd_en   (accept && emit_item),
        .rd_addr (pos_cur[rpbt_pkg::LS_AW-1:0]),
        .rd_data (held)
    );

    rpbt_col_emit u_col_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .blk_valid     (st1_valid_reg),
        .blk           (st1_blk_reg),
        .held          (held),
        .invert        (invert_reg),
        .bottom_first  (bottom_first_reg),
        .blk_ready     (blk_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column_byte (m_column_byte),
        .m_band_end    (m_band_end),
        .m_group_last  (m_group_last)
    );

`ifndef SYNTHESIS
    a_read_not_over_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit_item |-> !st1_valid_reg || blk_ready)
        else $error("line store read would overwrite a pending block");

    a_emit_item_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit_item |=> st1_valid_reg)
        else $error("eighth-row word lost before the emitter");

    a_no_store_write_on_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !emit_item && $onehot(wr_lane))
        else $error("line store written for an eighth-row word");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !st1_valid_reg && !m_valid)
        else $error("control state not cleared by reset");
`endif

endmodule

>>> sv/rpbt_line_store.sv
// line store: seven kept rows per byte position, byte-lane writes, registered read
module rpbt_line_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [rpbt_pkg::LS_AW-1:0]  wr_addr,
    input  logic [rpbt_pkg::ROWS_KEPT-1:0] wr_lane,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [rpbt_pkg::LS_AW-1:0]  rd_addr,
    output logic [rpbt_pkg::LS_DW-1:0]  rd_data
);

    logic [rpbt_pkg::LS_DW-1:0] mem [rpbt_pkg::MAX_LINE_BYTES];
    logic [rpbt_pkg::LS_DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < rpbt_pkg::ROWS_KEPT; i++) begin
                if (wr_lane[i]) begin
                    mem[wr_addr][8*i +: 8] <= wr_data;
                end
            end
        end
    end

    // read data only moves on a read, so it holds while the consumer stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/rpbt_col_emit.sv
// column emitter: transposes one band byte column block and sends its column words
module rpbt_col_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       blk_valid,
    input  rpbt_pkg::blk_t             blk,
    input  logic [rpbt_pkg::LS_DW-1:0] held,
    input  logic                       invert,
    input  logic                       bottom_first,
    output logic                       blk_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_column_byte,
    output logic                       m_band_end,
    output logic                       m_group_last
);

    logic        valid_reg, valid_next;
    logic [63:0] cols_reg, cols_next;
    logic [2:0]  left_reg, left_next;
    logic        band_end_reg, band_end_next;
    logic [63:0] cols_t;
    logic [7:0]  row_byte;
    logic        last_word;
    logic        load;

    // column b of the block lands in bits 8b..8b+7
    always_comb begin
        cols_t = '0;
        for (int k = 0; k < 8; k++) begin
            row_byte = (k < rpbt_pkg::ROWS_KEPT) ? held[8*k +: 8] : blk.last_row;
            for (int b = 0; b < 8; b++) begin
                if (bottom_first) begin
                    cols_t[8*b + 7 - k] = row_byte[7-b];
                end else begin
                    cols_t[8*b + k] = row_byte[7-b];
                end
            end
        end
        if (invert) begin
            cols_t = cols_t ^ {8{rpbt_pkg::INVERT_MASK}};
        end
    end

    assign last_word = (left_reg == 3'd0);
    assign blk_ready = !valid_reg || (m_ready && last_word);
    assign load      = blk_valid && blk_ready;

    always_comb begin
        valid_next    = valid_reg;
        cols_next     = cols_reg;
        left_next     = left_reg;
        band_end_next = band_end_reg;
        if (load) begin
            valid_next    = 1'b1;
            cols_next     = cols_t;
            left_next     = blk.cnt_m1;
            band_end_next = blk.band_end;
        end else if (valid_reg && m_ready) begin
            if (last_word) begin
                valid_next = 1'b0;
            end else begin
                cols_next = {8'h00, cols_reg[63:8]};
                left_next = left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cols_reg     <= cols_next;
        band_end_reg <= band_end_next;
    end

    assign m_valid       = valid_reg;
    assign m_column_byte = cols_reg[7:0];
    assign m_group_last  = last_word;
    assign m_band_end    = last_word && band_end_reg;

`ifndef SYNTHESIS
    a_band_end_closes_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_band_end |-> m_group_last)
        else $error("band end word is not the last of its group");

    a_group_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_group_last |=> m_valid)
        else $error("column group broken off before its last word");

    a_load_only_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        load && valid_reg |-> m_ready && left_reg == 3'd0)
        else $error("new block loaded over undelivered columns");
`endif

endmodule
